FILE: src/box_blur_7x7_clamped_top_assert.svh
// Assertion macros shared by the box blur RTL.
// No dependencies; included by the modules that carry checks.
`ifndef BOX_BLUR_7X7_CLAMPED_TOP_ASSERT_SVH
`define BOX_BLUR_7X7_CLAMPED_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define BB7C_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bb7c: same-cycle check failed");
`define BB7C_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bb7c: next-cycle check failed");
`else
`define BB7C_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define BB7C_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: src/bb7c_pkg.sv
// Package for the box blur block: payload structs, register indexes and defaults.
// No dependencies.
package bb7c_pkg;

  localparam int MAX_WIDTH_DEF    = 2048;
  localparam int KERNEL_SIZE_DEF  = 7;
  localparam int MAX_CHANNELS_DEF = 4;
  localparam int MAX_HEIGHT       = 4096;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 13;
  localparam int IMG_W_W     = 12;
  localparam int IMG_H_W     = 13;
  localparam int CHAN_CNT_W  = 3;
  localparam int POS_X_W     = 11;
  localparam int POS_Y_W     = 12;

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_COUNT = 2'd2;

  localparam logic [IMG_W_W-1:0]    IMAGE_WIDTH_RST   = 12'd640;
  localparam logic [IMG_H_W-1:0]    IMAGE_HEIGHT_RST  = 13'd480;
  localparam logic [CHAN_CNT_W-1:0] CHANNEL_COUNT_RST = 3'd3;

  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_DRAIN = 1'b1;

  typedef struct packed {
    logic       func;
    logic [7:0] chan0_in;
    logic [7:0] chan1_in;
    logic [7:0] chan2_in;
    logic [7:0] chan3_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         chan0_out;
    logic [7:0]         chan1_out;
    logic [7:0]         chan2_out;
    logic [7:0]         chan3_out;
    logic [POS_X_W-1:0] pos_x;
    logic [POS_Y_W-1:0] pos_y;
    logic               frame_last;
  } out_item_t;

endpackage

FILE: src/bb7c_line_store.sv
// Pixel store of the box blur: single write port, single registered read port.
// No dependencies.
module bb7c_line_store #(
  parameter int AW = 14,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/bb7c_div.sv
// Bit-serial restoring divider, one lane per channel sharing the divisor.
// No dependencies; one quotient bit per lane per cycle.
module bb7c_div #(
  parameter int LANES = 4,
  parameter int SUMW  = 14,
  parameter int AREAW = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SUMW-1:0]  sums [LANES],
  input  logic [AREAW-1:0] divisor,
  output logic             done,
  output logic [7:0]       quot [LANES]
);

  localparam int CW = $clog2(SUMW + 1);

  logic             busy;
  logic [CW-1:0]    cnt;
  logic [SUMW-1:0]  num [LANES];
  logic [AREAW-1:0] rem [LANES];
  logic [SUMW-1:0]  num_next [LANES];
  logic [AREAW-1:0] rem_next [LANES];

  always_comb begin
    logic [AREAW:0] shifted;
    logic           qbit;
    for (int c = 0; c < LANES; c++) begin
      shifted = {rem[c], num[c][SUMW-1]};
      qbit    = (shifted >= {1'b0, divisor});
      if (qbit) begin
        rem_next[c] = AREAW'(shifted - {1'b0, divisor});
      end else begin
        rem_next[c] = shifted[AREAW-1:0];
      end
      num_next[c] = {num[c][SUMW-2:0], qbit};
      quot[c]     = num[c][7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(SUMW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // The quotient shifts into the dividend register as the dividend leaves it.
  always_ff @(posedge clk) begin
    for (int c = 0; c < LANES; c++) begin
      if (start) begin
        num[c] <= sums[c];
        rem[c] <= '0;
      end else if (busy) begin
        num[c] <= num_next[c];
        rem[c] <= rem_next[c];
      end
    end
  end

endmodule

FILE: src/box_blur_7x7_clamped_top.sv
// Box blur, clipped 7x7 mean over a raster stream, once primed one result per pixel item
// (and per drain item after the frame's last pixel). An item without a result is taken
// in the idle state. With a result, the block reads each window pixel from the store,
// divides serially and registers the pixel; the next item is taken only after S_PUSH.
// Synchronous reset clears control and restores configuration defaults, not the line store.
// Depends on bb7c_pkg, bb7c_line_store, bb7c_div and the assertion header.
module box_blur_7x7_clamped_top #(
  parameter int MAX_WIDTH    = bb7c_pkg::MAX_WIDTH_DEF,
  parameter int KERNEL_SIZE  = bb7c_pkg::KERNEL_SIZE_DEF,
  parameter int MAX_CHANNELS = bb7c_pkg::MAX_CHANNELS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  bb7c_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output bb7c_pkg::out_item_t              out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bb7c_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bb7c_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int HALF  = KERNEL_SIZE / 2;
  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int YW    = bb7c_pkg::POS_Y_W;
  localparam int HW    = bb7c_pkg::IMG_H_W;
  localparam int AW    = $clog2(2 * HALF * MAX_WIDTH + 2 * HALF + 1);
  localparam int LATW  = $clog2(HALF * MAX_WIDTH + HALF + 1);
  localparam int SUMW  = $clog2(KERNEL_SIZE * KERNEL_SIZE * 255 + 1);
  localparam int AREAW = $clog2(KERNEL_SIZE * KERNEL_SIZE + 1);
  localparam int DW    = 8 * MAX_CHANNELS;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_READ   = 3'd1;
  localparam logic [2:0] S_FLUSH  = 3'd2;
  localparam logic [2:0] S_DSTART = 3'd3;
  localparam logic [2:0] S_DIV    = 3'd4;
  localparam logic [2:0] S_PUSH   = 3'd5;

  logic [2:0] state;

  logic [bb7c_pkg::IMG_W_W-1:0]    image_width;
  logic [bb7c_pkg::IMG_H_W-1:0]    image_height;
  logic [bb7c_pkg::CHAN_CNT_W-1:0] channel_count;

  logic [WW-1:0]   w;
  logic [HW-1:0]   h;
  logic [2:0]      nch;
  logic [LATW-1:0] lat;

  // Frame progress.
  logic [XW-1:0]   ix;
  logic [YW-1:0]   iy;
  logic [XW-1:0]   ox;
  logic [YW-1:0]   oy;
  logic [AW-1:0]   wptr;
  logic [AW-1:0]   pk;
  logic [LATW-1:0] lat_cnt;
  logic            in_done;

  // Window walk.
  logic [XW-1:0]    rx;
  logic [YW-1:0]    ry;
  logic [XW-1:0]    x0_q;
  logic [XW-1:0]    x1_q;
  logic [YW-1:0]    y1_q;
  logic [AW-1:0]    addr;
  logic [AW-1:0]    row_addr;
  logic             rd_valid;
  logic [DW-1:0]    rd_data;
  logic [SUMW-1:0]  sums [MAX_CHANNELS];
  logic [AREAW-1:0] area;

  logic             div_done;
  logic [7:0]       quot [MAX_CHANNELS];

  logic            acc;
  logic            is_pixel;
  logic            counted;
  logic            wr_en;
  logic            emit;
  logic            cfg_hit;
  logic            rd_last;
  logic            push_fire;
  logic            in_last;
  logic            out_last;
  logic [XW-1:0]   x0;
  logic [XW-1:0]   x1;
  logic [YW-1:0]   y0;
  logic [YW-1:0]   y1;
  logic [AW-1:0]   start_addr;
  logic [DW-1:0]   wdata;
  logic [7:0]      in_bytes [4];
  logic [7:0]      out_bytes [4];

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);

  // Registers are used saturated into their legal ranges.
  always_comb begin
    if (image_width == '0) begin
      w = WW'(1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = WW'(image_width);
    end
    if (image_height == '0) begin
      h = HW'(1);
    end else if (32'(image_height) > bb7c_pkg::MAX_HEIGHT) begin
      h = HW'(bb7c_pkg::MAX_HEIGHT);
    end else begin
      h = image_height;
    end
    if (channel_count == '0) begin
      nch = 3'd1;
    end else if (32'(channel_count) > MAX_CHANNELS) begin
      nch = 3'(MAX_CHANNELS);
    end else begin
      nch = channel_count;
    end
    lat = LATW'(HALF * 32'(w) + HALF);
  end

  assign acc       = in_valid && in_ready;
  assign is_pixel  = (in_data.func == bb7c_pkg::FUNC_PIXEL);
  assign counted   = in_done || is_pixel;
  assign wr_en     = acc && !in_done && is_pixel;
  assign emit      = acc && counted && (lat_cnt == lat);
  assign cfg_hit   = cfg_valid && cfg_ready && (cfg_index == bb7c_pkg::REG_IMAGE_WIDTH ||
                     cfg_index == bb7c_pkg::REG_IMAGE_HEIGHT ||
                     cfg_index == bb7c_pkg::REG_CHANNEL_COUNT);
  assign rd_last   = (state == S_READ) && (rx == x1_q) && (ry == y1_q);
  assign push_fire = (state == S_PUSH) && (!out_valid || out_ready);
  assign in_last   = (ix == XW'(w - 1'b1)) && (iy == YW'(h - 1'b1));
  assign out_last  = (ox == XW'(w - 1'b1)) && (oy == YW'(h - 1'b1));

  // Clipped window of the pixel due out, and the store address of its corner.
  always_comb begin
    logic [YW-1:0] dy;
    logic [XW-1:0] dx;
    if (32'(ox) >= HALF) begin
      x0 = ox - XW'(HALF);
    end else begin
      x0 = '0;
    end
    if (32'(ox) + HALF < 32'(w)) begin
      x1 = ox + XW'(HALF);
    end else begin
      x1 = XW'(w - 1'b1);
    end
    if (32'(oy) >= HALF) begin
      y0 = oy - YW'(HALF);
    end else begin
      y0 = '0;
    end
    if (32'(oy) + HALF < 32'(h)) begin
      y1 = oy + YW'(HALF);
    end else begin
      y1 = YW'(h - 1'b1);
    end
    dx = ox - x0;
    dy = oy - y0;
    start_addr = pk - AW'(32'(dy) * 32'(w)) - AW'(dx);
  end

  always_comb begin
    in_bytes[0] = in_data.chan0_in;
    in_bytes[1] = in_data.chan1_in;
    in_bytes[2] = in_data.chan2_in;
    in_bytes[3] = in_data.chan3_in;
    for (int c = 0; c < MAX_CHANNELS; c++) begin
      wdata[8*c +: 8] = in_bytes[c];
    end
    for (int c = 0; c < 4; c++) begin
      out_bytes[c] = 8'd0;
    end
    for (int c = 0; c < MAX_CHANNELS; c++) begin
      if (c < 32'(nch)) begin
        out_bytes[c] = quot[c];
      end
    end
  end

  bb7c_line_store #(
    .AW(AW),
    .DW(DW)
  ) u_store (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wptr),
    .wdata(wdata),
    .re   (state == S_READ),
    .raddr(addr),
    .rdata(rd_data)
  );

  bb7c_div #(
    .LANES(MAX_CHANNELS),
    .SUMW (SUMW),
    .AREAW(AREAW)
  ) u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (state == S_DSTART),
    .sums   (sums),
    .divisor(area),
    .done   (div_done),
    .quot   (quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      image_width   <= bb7c_pkg::IMAGE_WIDTH_RST;
      image_height  <= bb7c_pkg::IMAGE_HEIGHT_RST;
      channel_count <= bb7c_pkg::CHANNEL_COUNT_RST;
      ix            <= '0;
      iy            <= '0;
      ox            <= '0;
      oy            <= '0;
      wptr          <= '0;
      pk            <= '0;
      lat_cnt       <= '0;
      in_done       <= 1'b0;
      rd_valid      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      rd_valid <= (state == S_READ);
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          bb7c_pkg::REG_IMAGE_WIDTH:   image_width   <= cfg_data[bb7c_pkg::IMG_W_W-1:0];
          bb7c_pkg::REG_IMAGE_HEIGHT:  image_height  <= cfg_data[bb7c_pkg::IMG_H_W-1:0];
          bb7c_pkg::REG_CHANNEL_COUNT: channel_count <= cfg_data[bb7c_pkg::CHAN_CNT_W-1:0];
          default: ;
        endcase
      end
      if (cfg_hit) begin
        ix      <= '0;
        iy      <= '0;
        ox      <= '0;
        oy      <= '0;
        wptr    <= '0;
        pk      <= '0;
        lat_cnt <= '0;
        in_done <= 1'b0;
      end else begin
        if (wr_en) begin
          wptr <= wptr + 1'b1;
          if (in_last) begin
            in_done <= 1'b1;
          end
          if (ix == XW'(w - 1'b1)) begin
            ix <= '0;
            iy <= iy + 1'b1;
          end else begin
            ix <= ix + 1'b1;
          end
        end
        if (acc && counted && (lat_cnt != lat)) begin
          lat_cnt <= lat_cnt + 1'b1;
        end
        if (push_fire) begin
          // The last pixel of the frame restarts every counter for the next frame.
          if (out_last) begin
            ix      <= '0;
            iy      <= '0;
            ox      <= '0;
            oy      <= '0;
            wptr    <= '0;
            pk      <= '0;
            lat_cnt <= '0;
            in_done <= 1'b0;
          end else begin
            pk <= pk + 1'b1;
            if (ox == XW'(w - 1'b1)) begin
              ox <= '0;
              oy <= oy + 1'b1;
            end else begin
              ox <= ox + 1'b1;
            end
          end
        end
      end
      if (push_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (emit) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          if (rd_last) begin
            state <= S_FLUSH;
          end
        end
        S_FLUSH:  state <= S_DSTART;
        S_DSTART: state <= S_DIV;
        S_DIV: begin
          if (div_done) begin
            state <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (push_fire) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Window walk and accumulation; read data arrives in the cycle after its address is issued.
  always_ff @(posedge clk) begin
    if (emit) begin
      rx       <= x0;
      ry       <= y0;
      x0_q     <= x0;
      x1_q     <= x1;
      y1_q     <= y1;
      addr     <= start_addr;
      row_addr <= start_addr;
      area     <= '0;
      for (int c = 0; c < MAX_CHANNELS; c++) begin
        sums[c] <= '0;
      end
    end else begin
      if (state == S_READ) begin
        if (rx == x1_q) begin
          rx       <= x0_q;
          ry       <= ry + 1'b1;
          row_addr <= row_addr + AW'(w);
          addr     <= row_addr + AW'(w);
        end else begin
          rx   <= rx + 1'b1;
          addr <= addr + 1'b1;
        end
      end
      if (rd_valid) begin
        area <= area + 1'b1;
        for (int c = 0; c < MAX_CHANNELS; c++) begin
          sums[c] <= sums[c] + SUMW'(rd_data[8*c +: 8]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) begin
      out_data.chan0_out  <= out_bytes[0];
      out_data.chan1_out  <= out_bytes[1];
      out_data.chan2_out  <= out_bytes[2];
      out_data.chan3_out  <= out_bytes[3];
      out_data.pos_x      <= bb7c_pkg::POS_X_W'(ox);
      out_data.pos_y      <= oy;
      out_data.frame_last <= out_last;
    end
  end

`include "box_blur_7x7_clamped_top_assert.svh"

  `BB7C_ASSERT_NEXT(a_read_returns, clk, rst, state == S_READ, rd_valid)
  `BB7C_ASSERT_IMPLY(a_read_origin, clk, rst, rd_valid, $past(state) == S_READ)
  `BB7C_ASSERT_IMPLY(a_area_nonzero, clk, rst, state == S_DSTART, area != '0)
  `BB7C_ASSERT_IMPLY(a_div_in_state, clk, rst, div_done, state == S_DIV)
  `BB7C_ASSERT_IMPLY(a_out_from_push, clk, rst, $rose(out_valid), $past(state) == S_PUSH)

endmodule

FILE: bench/testbench.sv
// Self-checking bench for the clipped 7x7 box blur: random frames, stalls and config changes.
// Depends on bb7c_pkg and box_blur_7x7_clamped_top; the scoreboard below predicts pixels.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_DEPTH = 7 * 2048 + 7;
  localparam int IDLE_LIMIT = 6000;

  class blur_scoreboard;
    int unsigned width_reg, height_reg, chans_reg;
    int unsigned pixels_in, pixels_out;
    int unsigned ring [RING_DEPTH];
    bb7c_pkg::out_item_t awaited [$];
    int          errors;

    function new();
      width_reg  = 32'(bb7c_pkg::IMAGE_WIDTH_RST);
      height_reg = 32'(bb7c_pkg::IMAGE_HEIGHT_RST);
      chans_reg  = 32'(bb7c_pkg::CHANNEL_COUNT_RST);
      pixels_in  = 0;
      pixels_out = 0;
      errors     = 0;
    endfunction

    function int unsigned clip(int unsigned v, int unsigned lo, int unsigned hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function void write_reg(logic [bb7c_pkg::CFG_INDEX_W-1:0] idx,
                            logic [bb7c_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        bb7c_pkg::REG_IMAGE_WIDTH: width_reg = 32'(val[bb7c_pkg::IMG_W_W-1:0]);
        bb7c_pkg::REG_IMAGE_HEIGHT: height_reg = 32'(val[bb7c_pkg::IMG_H_W-1:0]);
        bb7c_pkg::REG_CHANNEL_COUNT: chans_reg = 32'(val[bb7c_pkg::CHAN_CNT_W-1:0]);
        default: return;
      endcase
      pixels_in  = 0;
      pixels_out = 0;
    endfunction

    // Works out the blurred pixel, if any, that leaves with this transfer.
    function void note_input(bb7c_pkg::in_item_t it);
      int unsigned w, h, nch, frame_px, lat, n, k, x, y, x0, x1, y0, y1, area, px;
      int unsigned acc [4];
      bb7c_pkg::out_item_t exp_px;
      w = clip(width_reg, 1, 2048);
      h = clip(height_reg, 1, bb7c_pkg::MAX_HEIGHT);
      nch = clip(chans_reg, 1, 4);
      frame_px = w * h;
      lat = 3 * w + 3;
      n = pixels_in;
      if (n < frame_px) begin
        if (it.func == bb7c_pkg::FUNC_DRAIN) return;
        ring[n % RING_DEPTH] = {it.chan3_in, it.chan2_in, it.chan1_in, it.chan0_in};
      end
      pixels_in = n + 1;
      if (n < lat) return;
      k = pixels_out;
      x = k % w;
      y = k / w;
      x0 = (x >= 3) ? x - 3 : 0;
      y0 = (y >= 3) ? y - 3 : 0;
      x1 = (x + 3 < w) ? x + 3 : w - 1;
      y1 = (y + 3 < h) ? y + 3 : h - 1;
      area = (x1 - x0 + 1) * (y1 - y0 + 1);
      acc = '{0, 0, 0, 0};
      for (int unsigned r = y0; r <= y1; r++) begin
        for (int unsigned c = x0; c <= x1; c++) begin
          px = ring[(r * w + c) % RING_DEPTH];
          for (int b = 0; b < 4; b++) acc[b] += (px >> (8 * b)) & 8'hFF;
        end
      end
      exp_px.chan0_out = 8'(acc[0] / area);
      exp_px.chan1_out = (nch > 1) ? 8'(acc[1] / area) : 8'd0;
      exp_px.chan2_out = (nch > 2) ? 8'(acc[2] / area) : 8'd0;
      exp_px.chan3_out = (nch > 3) ? 8'(acc[3] / area) : 8'd0;
      exp_px.pos_x = bb7c_pkg::POS_X_W'(x);
      exp_px.pos_y = bb7c_pkg::POS_Y_W'(y);
      exp_px.frame_last = (k + 1 >= frame_px);
      if (exp_px.frame_last) begin
        pixels_in  = 0;
        pixels_out = 0;
      end else begin
        pixels_out = k + 1;
      end
      awaited.push_back(exp_px);
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(bb7c_pkg::out_item_t got);
      bb7c_pkg::out_item_t e;
      if (awaited.size() == 0) begin
        report($sformatf("unexpected pixel %p", got));
        return;
      end
      e = awaited.pop_front();
      if (got.chan0_out !== e.chan0_out)
        report($sformatf("chan0 got %0d want %0d", got.chan0_out, e.chan0_out));
      if (got.chan1_out !== e.chan1_out)
        report($sformatf("chan1 got %0d want %0d", got.chan1_out, e.chan1_out));
      if (got.chan2_out !== e.chan2_out)
        report($sformatf("chan2 got %0d want %0d", got.chan2_out, e.chan2_out));
      if (got.chan3_out !== e.chan3_out)
        report($sformatf("chan3 got %0d want %0d", got.chan3_out, e.chan3_out));
      if (got.pos_x !== e.pos_x)
        report($sformatf("pos_x got %0d want %0d", got.pos_x, e.pos_x));
      if (got.pos_y !== e.pos_y)
        report($sformatf("pos_y got %0d want %0d", got.pos_y, e.pos_y));
      if (got.frame_last !== e.frame_last)
        report($sformatf("frame_last got %0b want %0b", got.frame_last, e.frame_last));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0, in_ready;
  bb7c_pkg::in_item_t in_data = '0;
  logic out_valid, out_ready = 1'b0;
  bb7c_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [bb7c_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [bb7c_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  blur_scoreboard sb = new();
  int  items_sent = 0;
  int  idle_cycles = 0;
  bit  hold_request = 1'b0;

  box_blur_7x7_clamped_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic write_reg(logic [bb7c_pkg::CFG_INDEX_W-1:0] idx,
                           logic [bb7c_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(int w, int h, int c);
    write_reg(bb7c_pkg::REG_IMAGE_WIDTH, bb7c_pkg::CFG_DATA_W'(w));
    write_reg(bb7c_pkg::REG_IMAGE_HEIGHT, bb7c_pkg::CFG_DATA_W'(h));
    write_reg(bb7c_pkg::REG_CHANNEL_COUNT, bb7c_pkg::CFG_DATA_W'(c));
  endtask

  task automatic send_item(bb7c_pkg::in_item_t it);
    int g;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_input(it);
    items_sent++;
    g = gap_len();
    if (g > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (g - 1) @(negedge clk);
    end
  endtask

  function automatic bb7c_pkg::in_item_t rand_pixel(logic fn);
    bb7c_pkg::in_item_t it;
    it = bb7c_pkg::in_item_t'({1'b0, $urandom});
    it.func = fn;
    return it;
  endfunction

  // Waits until every predicted pixel has arrived and the block has settled.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // One whole frame: pixels with stray drains among them, then the flush transfers.
  task automatic run_frame(int w, int h, int extreme);
    int wc, hc;
    bb7c_pkg::in_item_t it;
    wc = (w < 1) ? 1 : ((w > 2048) ? 2048 : w);
    hc = (h < 1) ? 1 : ((h > 4096) ? 4096 : h);
    for (int i = 0; i < wc * hc; i++) begin
      if ($urandom_range(0, 11) == 0) send_item(rand_pixel(bb7c_pkg::FUNC_DRAIN));
      it = rand_pixel(bb7c_pkg::FUNC_PIXEL);
      if (extreme != 0) it = (i % 2 == 0) ? '0 : {bb7c_pkg::FUNC_PIXEL, 32'hFFFF_FFFF};
      send_item(it);
    end
    for (int i = 0; i < 3 * wc + 3; i++)
      send_item(rand_pixel($urandom_range(0, 2) == 0 ? bb7c_pkg::FUNC_PIXEL
                                                      : bb7c_pkg::FUNC_DRAIN));
  endtask

  initial begin
    int w, h;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Zero registers saturate to a single one-channel pixel; the leading drain is ignored.
    configure(0, 0, 0);
    send_item(rand_pixel(bb7c_pkg::FUNC_DRAIN));
    send_item({bb7c_pkg::FUNC_PIXEL, 32'hFFFF_FFFF});
    repeat (6) send_item(rand_pixel(bb7c_pkg::FUNC_DRAIN));
    settle();

    // Widest and tallest settings: a partial frame that never produces a pixel.
    configure(4095, 8191, 7);
    repeat (20) send_item(rand_pixel(bb7c_pkg::FUNC_PIXEL));
    settle();
    write_reg(bb7c_pkg::REG_IMAGE_HEIGHT, bb7c_pkg::CFG_DATA_W'(1));
    repeat (20) send_item(rand_pixel(bb7c_pkg::FUNC_PIXEL));
    settle();

    configure(5, 4, 4);
    run_frame(5, 4, 1);
    settle();
    configure(1, 9, 2);
    run_frame(1, 9, 0);
    settle();

    hold_request = 1'b1;
    while (items_sent < 410) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12);
      h = $urandom_range(1, 9);
      configure(w, h, $urandom_range(0, 7));
      repeat ($urandom_range(1, 2)) run_frame(w, h, 0);
      settle();
    end

    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Receiver: random stalls, plus one long hold so that the block backs up.
  initial begin
    int g;
    forever begin
      @(negedge clk);
      if (hold_request && !rst) begin
        out_ready <= 1'b0;
        repeat (400) @(negedge clk);
        hold_request = 1'b0;
        out_ready <= 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        g = gap_len();
        if (g > 0) begin
          out_ready <= 1'b0;
          repeat (g) @(negedge clk);
        end
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end
endmodule

FILE: box_blur_7x7_clamped_top.f
+incdir+src
src/bb7c_pkg.sv
src/bb7c_line_store.sv
src/bb7c_div.sv
src/box_blur_7x7_clamped_top.sv
bench/testbench.sv
